// ===== src/fnpc_pkg.sv =====
`default_nettype none

package fnpc_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int PIXEL_BITS     = 16;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS    = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [WIDTH_BITS-1:0]  MAX_WIDTH_W    = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET    = WIDTH_BITS'(1024);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET   = HEIGHT_BITS'(1);

   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_FLUSH = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [COL_BITS-1:0]   col_type;

   typedef struct packed {
      pixel_type value;
      logic      last_in_row;
      logic      last_in_frame;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/four_neighbor_peak_clip_unit.sv =====
// Output: a result is registered in the output stage (the skid stage if rsp stalls)
//   by the request that completes it (the pixel one row below, or a flush request
//   for the last row). Throughput: one request per cycle while req_stall is low; line
//   stores are read one request ahead so the memory's registered read is hidden.
// Reset: positions, left neighbor, output stages and registers return to defaults;
//   line stores are not cleared and are always written before they are read.
`default_nettype none

module four_neighbor_peak_clip_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_type,
   input  wire  [fnpc_pkg::PIXEL_BITS-1:0]       req_pixel,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [fnpc_pkg::PIXEL_BITS-1:0]       rsp_value,
   output logic                                  rsp_last_in_row,
   output logic                                  rsp_last_in_frame,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [fnpc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [fnpc_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   fnpc_pkg::pixel_type pending_mem [fnpc_pkg::MAX_WIDTH];
   fnpc_pkg::pixel_type result_mem  [fnpc_pkg::MAX_WIDTH];

   logic [fnpc_pkg::WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [fnpc_pkg::HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   fnpc_pkg::col_type                in_col_ff, in_col_in;
   logic [fnpc_pkg::HEIGHT_BITS-1:0] in_line_ff, in_line_in;
   fnpc_pkg::col_type                out_col_ff, out_col_in;
   logic [fnpc_pkg::HEIGHT_BITS-1:0] out_line_ff, out_line_in;
   fnpc_pkg::pixel_type              left_ff, left_in;

   fnpc_pkg::pixel_type              orig_ff, right_ff, up_ff;

   logic                             out_valid_ff, out_valid_in;
   logic                             skid_valid_ff, skid_valid_in;
   fnpc_pkg::rsp_type                out_ff, out_in;
   fnpc_pkg::rsp_type                skid_ff, skid_in;

   logic [fnpc_pkg::WIDTH_BITS-1:0]  eff_w;
   logic [fnpc_pkg::HEIGHT_BITS-1:0] eff_h;
   logic                             accept, is_pixel, frame_in, pix_go, emit, csr_go;
   logic                             has_up, has_down, has_left, has_right, any_nb, peak;
   logic                             end_row, end_frame, restart;
   fnpc_pkg::pixel_type              best, res;
   fnpc_pkg::col_type                rd_col, rd_col_next;
   fnpc_pkg::rsp_type                new_rsp;
   logic                             pop;

   assign req_stall         = skid_valid_ff;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = out_valid_ff;
   assign rsp_value         = out_ff.value;
   assign rsp_last_in_row   = out_ff.last_in_row;
   assign rsp_last_in_frame = out_ff.last_in_frame;

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = fnpc_pkg::WIDTH_BITS'(1);
      end else if (frame_width_ff > fnpc_pkg::MAX_WIDTH_W) begin
         eff_w = fnpc_pkg::MAX_WIDTH_W;
      end else begin
         eff_w = frame_width_ff;
      end
      eff_h = (frame_height_ff == '0) ? fnpc_pkg::HEIGHT_BITS'(1) : frame_height_ff;

      accept   = req_valid && !req_stall;
      is_pixel = (req_type == fnpc_pkg::REQ_PIXEL);
      frame_in = in_line_ff < eff_h;
      pix_go   = accept && is_pixel && frame_in;
      emit     = (pix_go && (in_line_ff != '0)) || (accept && !is_pixel && !frame_in);
      csr_go   = csr_valid && csr_ready &&
                 ((csr_index == fnpc_pkg::CSR_FRAME_WIDTH) ||
                  (csr_index == fnpc_pkg::CSR_FRAME_HEIGHT));

      has_up    = out_line_ff != '0;
      has_down  = is_pixel;
      has_left  = out_col_ff != '0;
      has_right = ({1'b0, out_col_ff} + fnpc_pkg::WIDTH_BITS'(1)) < eff_w;
      any_nb    = has_up || has_down || has_left || has_right;

      peak = !((has_up    && (up_ff     >= orig_ff)) ||
               (has_down  && (req_pixel >= orig_ff)) ||
               (has_left  && (left_ff   >= orig_ff)) ||
               (has_right && (right_ff  >= orig_ff)));

      best = '0;
      if (has_up    && (up_ff     > best)) best = up_ff;
      if (has_down  && (req_pixel > best)) best = req_pixel;
      if (has_left  && (left_ff   > best)) best = left_ff;
      if (has_right && (right_ff  > best)) best = right_ff;
      res = (peak && any_nb) ? best : orig_ff;

      end_row   = ({1'b0, out_col_ff} + fnpc_pkg::WIDTH_BITS'(1)) == eff_w;
      end_frame = end_row &&
                  (({1'b0, out_line_ff} + 17'd1) >= {1'b0, eff_h});

      new_rsp.value         = res;
      new_rsp.last_in_row   = end_row;
      new_rsp.last_in_frame = end_frame;

      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      in_col_in       = in_col_ff;
      in_line_in      = in_line_ff;
      out_col_in      = out_col_ff;
      out_line_in     = out_line_ff;
      left_in         = left_ff;

      if (pix_go) begin
         if (({1'b0, in_col_ff} + fnpc_pkg::WIDTH_BITS'(1)) >= eff_w) begin
            in_col_in  = '0;
            in_line_in = in_line_ff + fnpc_pkg::HEIGHT_BITS'(1);
         end else begin
            in_col_in = in_col_ff + fnpc_pkg::COL_BITS'(1);
         end
      end

      if (emit) begin
         left_in = res;
         if (end_row) begin
            out_col_in  = '0;
            out_line_in = out_line_ff + fnpc_pkg::HEIGHT_BITS'(1);
         end else begin
            out_col_in = out_col_ff + fnpc_pkg::COL_BITS'(1);
         end
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fnpc_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_data[fnpc_pkg::WIDTH_BITS-1:0];
            fnpc_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data[fnpc_pkg::HEIGHT_BITS-1:0];
            default: ;
         endcase
      end

      restart = csr_go || (emit && !is_pixel && end_frame);
      if (restart) begin
         in_col_in   = '0;
         in_line_in  = '0;
         out_col_in  = '0;
         out_line_in = '0;
         left_in     = '0;
      end

      rd_col      = out_col_in;
      rd_col_next = out_col_in + fnpc_pkg::COL_BITS'(1);

      pop           = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_rsp;
            out_valid_in = emit;
         end
      end else if (emit) begin
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= fnpc_pkg::WIDTH_RESET;
         frame_height_ff <= fnpc_pkg::HEIGHT_RESET;
         in_col_ff       <= '0;
         in_line_ff      <= '0;
         out_col_ff      <= '0;
         out_line_ff     <= '0;
         left_ff         <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         in_col_ff       <= in_col_in;
         in_line_ff      <= in_line_in;
         out_col_ff      <= out_col_in;
         out_line_ff     <= out_line_in;
         left_ff         <= left_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (pix_go) begin
         pending_mem[in_col_ff] <= req_pixel;
      end
      orig_ff  <= (pix_go && (in_col_ff == rd_col)) ? req_pixel : pending_mem[rd_col];
      right_ff <= (pix_go && (in_col_ff == rd_col_next)) ? req_pixel
                                                         : pending_mem[rd_col_next];
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         result_mem[out_col_ff] <= res;
      end
      up_ff <= (emit && (out_col_ff == rd_col)) ? res : result_mem[rd_col];
   end

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a result while the output stage is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid stage filled without a stalled output");

   a_pixel_aligned: assert property (@(posedge clock) disable iff (reset)
      (pix_go && (in_line_ff != '0)) |->
         ((in_col_ff == out_col_ff) && (in_line_ff == out_line_ff + 16'd1)))
      else $error("input and output positions out of step");

   a_out_col_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, out_col_ff} < eff_w) && ({1'b0, in_col_ff} < eff_w))
      else $error("column position beyond frame width");
`endif

endmodule

`default_nettype wire
